### rtl/mer_pkg.sv
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants of the midpoint ellipse rasterizer: phases,
// controller states, datapath command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package mer_pkg;

  localparam int unsigned COORD_BITS_DEF = 11;

  // request function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_R1,
    PH_R2,
    PH_DONE
  } phase_e;

  typedef enum logic [5:0] {
    S_WAIT,
    S_ST_1, S_ST_2, S_ST_3, S_ST_4, S_ST_5, S_ST_6,
    S_R1_M1, S_R1_M2, S_R1_CMP, S_R1_D1, S_R1_D2, S_R1_A1, S_R1_A2, S_R1_A3,
    S_SW_1, S_SW_2, S_SW_3, S_SW_4, S_SW_5, S_SW_6,
    S_R2_CHK, S_R2_M1, S_R2_A1, S_R2_M2, S_R2_A2, S_R2_A3,
    S_Q0, S_Q1, S_Q2, S_Q3,
    S_F0, S_F1, S_F2,
    S_NULL
  } ctl_state_e;

  // operand pairs of the shared multiplier
  typedef enum logic [3:0] {
    MUL_RX_RX,
    MUL_RY_RY,
    MUL_RXSQ_RY,
    MUL_RYSQ_X,
    MUL_RXSQ_Y,
    MUL_TX_TX,
    MUL_RYSQ_P,
    MUL_TY_TY,
    MUL_RXSQ_P,
    MUL_RXSQ_RYSQ
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_PROD,
    ACC_AUX,
    ACC_RX_SQ,
    ACC_RY_SQ
  } acc_src_e;

  typedef enum logic [2:0] {
    EMIT_Q0,
    EMIT_Q1,
    EMIT_Q2,
    EMIT_Q3,
    EMIT_F0,
    EMIT_F1,
    EMIT_F2,
    EMIT_NULL
  } emit_sel_e;

  typedef struct packed {
    logic      load;
    logic      mul_en;
    mul_sel_e  mul_sel;
    logic      aux_en;
    logic      rx_sq_en;
    logic      ry_sq_en;
    logic      acc_en;
    logic      acc_clr;
    acc_src_e  acc_src;
    logic [1:0] acc_shift;
    logic      acc_neg;
    logic      x_inc;
    logic      y_dec;
    logic      emit;
    emit_sel_e emit_sel;
    logic      emit_done;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic start_zero;
    logic cmp_le;
    logic dec_neg;
    logic dec_pos;
    logic y_pos;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/mer_if.sv
// ----------------------------------------------------------------------------
// mer_if
// Request and result channels of the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mer_in_if #(
  parameter int unsigned COORD_BITS = mer_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [COORD_BITS-1:0] radius_x;
  logic [COORD_BITS-1:0] radius_y;

  modport source (
    output valid, func, center_x, center_y, radius_x, radius_y,
    input  ready
  );
  modport sink (
    input  valid, func, center_x, center_y, radius_x, radius_y,
    output ready
  );
endinterface

interface mer_out_if #(
  parameter int unsigned COORD_BITS = mer_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS+1:0] pixel_x;
  logic signed [COORD_BITS+1:0] pixel_y;
  logic                         pixel_valid;
  logic                         last;
  logic                         done_res;

  modport source (
    output valid, pixel_x, pixel_y, pixel_valid, last, done_res,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_valid, last, done_res,
    output ready
  );
endinterface

`default_nettype wire

### rtl/midpoint_ellipse_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Midpoint ellipse rasterizer: start and step requests in, mirrored pixels out.
// ----------------------------------------------------------------------------
// start: no result; ready again once the start decision is computed; a
//   zero-radius start gives its 3 final points instead
// step: region 1 compare, decision update and 4 results (one result per cycle
//   while the output is free); region 2 check, update and 4 results; switch
//   recomputes d; all multiplies share one multiplier with a registered product
// idle/done step: one result with no valid pixel; reset clears phase to idle
`default_nettype none

module midpoint_ellipse_rasterizer #(
  parameter int unsigned COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mer_in_if.sink    in_i,
  mer_out_if.source out_o
);
  import mer_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  mer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_i.func),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  mer_dpath #(
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .center_x_i    (in_i.center_x),
    .center_y_i    (in_i.center_y),
    .radius_x_i    (in_i.radius_x),
    .radius_y_i    (in_i.radius_y),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .pixel_x_o     (out_o.pixel_x),
    .pixel_y_o     (out_o.pixel_y),
    .pixel_valid_o (out_o.pixel_valid),
    .last_o        (out_o.last),
    .done_res_o    (out_o.done_res)
  );

endmodule

`default_nettype wire

### rtl/mer_ctrl.sv
// ----------------------------------------------------------------------------
// mer_ctrl
// Sequencer of the rasterizer: walks the multiply and accumulate steps of
// each request and the emission of its result pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_func_i,
  output logic                    in_ready_o,
  input  wire mer_pkg::dp_stat_t  stat_i,
  output mer_pkg::dp_cmd_t        cmd_o
);
  import mer_pkg::*;

  ctl_state_e state_q, state_d;
  phase_e     phase_q, phase_d;
  dp_cmd_t    cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_WAIT;
      phase_q <= PH_IDLE;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    cmd        = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_WAIT: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (in_func_i)
            FUNC_START: begin
              cmd.load = 1'b1;
              if (stat_i.start_zero) begin
                phase_d = PH_DONE;
                state_d = S_F0;
              end else begin
                phase_d = PH_R1;
                state_d = S_ST_1;
              end
            end
            FUNC_STEP: begin
              unique case (phase_q)
                PH_R1:   state_d = S_R1_M1;
                PH_R2:   state_d = S_R2_CHK;
                PH_IDLE: state_d = S_NULL;
                PH_DONE: state_d = S_NULL;
              endcase
            end
          endcase
        end
      end
      // start: d = 4*ry^2 - 4*rx^2*ry + rx^2
      S_ST_1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RX_RX;
        state_d     = S_ST_2;
      end
      S_ST_2: begin
        cmd.rx_sq_en = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_RY_RY;
        state_d      = S_ST_3;
      end
      S_ST_3: begin
        cmd.ry_sq_en = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_RXSQ_RY;
        state_d      = S_ST_4;
      end
      S_ST_4: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_clr   = 1'b1;
        cmd.acc_src   = ACC_PROD;
        cmd.acc_shift = 2'd2;
        cmd.acc_neg   = 1'b1;
        state_d       = S_ST_5;
      end
      S_ST_5: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_src   = ACC_RY_SQ;
        cmd.acc_shift = 2'd2;
        state_d       = S_ST_6;
      end
      S_ST_6: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_src = ACC_RX_SQ;
        state_d     = S_WAIT;
      end
      // region 1 test: ry^2*x <= rx^2*y
      S_R1_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RYSQ_X;
        state_d     = S_R1_M2;
      end
      S_R1_M2: begin
        cmd.aux_en  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RXSQ_Y;
        state_d     = S_R1_CMP;
      end
      S_R1_CMP: begin
        if (stat_i.cmp_le) begin
          cmd.x_inc = 1'b1;
          if (stat_i.dec_neg) begin
            state_d = S_R1_A1;
          end else begin
            cmd.y_dec = 1'b1;
            state_d   = S_R1_D1;
          end
        end else begin
          state_d = S_SW_1;
        end
      end
      // -8*rx^2*(y-1) from the old product
      S_R1_D1: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_src   = ACC_PROD;
        cmd.acc_shift = 2'd3;
        cmd.acc_neg   = 1'b1;
        state_d       = S_R1_D2;
      end
      S_R1_D2: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_src   = ACC_RX_SQ;
        cmd.acc_shift = 2'd3;
        state_d       = S_R1_A1;
      end
      // +8*ry^2*(x+1) + 4*ry^2
      S_R1_A1: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_src   = ACC_AUX;
        cmd.acc_shift = 2'd3;
        state_d       = S_R1_A2;
      end
      S_R1_A2: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_src   = ACC_RY_SQ;
        cmd.acc_shift = 2'd3;
        state_d       = S_R1_A3;
      end
      S_R1_A3: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_src   = ACC_RY_SQ;
        cmd.acc_shift = 2'd2;
        state_d       = S_Q0;
      end
      // region switch: d = ry^2*tx^2 + 4*rx^2*ty^2 - 4*rx^2*ry^2
      S_SW_1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TX_TX;
        state_d     = S_SW_2;
      end
      S_SW_2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RYSQ_P;
        state_d     = S_SW_3;
      end
      S_SW_3: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_clr = 1'b1;
        cmd.acc_src = ACC_PROD;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TY_TY;
        state_d     = S_SW_4;
      end
      S_SW_4: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RXSQ_P;
        state_d     = S_SW_5;
      end
      S_SW_5: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_src   = ACC_PROD;
        cmd.acc_shift = 2'd2;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_RXSQ_RYSQ;
        state_d       = S_SW_6;
      end
      S_SW_6: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_src   = ACC_PROD;
        cmd.acc_shift = 2'd2;
        cmd.acc_neg   = 1'b1;
        phase_d       = PH_R2;
        state_d       = S_R2_CHK;
      end
      S_R2_CHK: begin
        if (stat_i.y_pos) begin
          cmd.y_dec = 1'b1;
          if (stat_i.dec_pos) begin
            state_d = S_R2_M2;
          end else begin
            cmd.x_inc = 1'b1;
            state_d   = S_R2_M1;
          end
        end else begin
          phase_d = PH_DONE;
          state_d = S_F0;
        end
      end
      S_R2_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RYSQ_X;
        state_d     = S_R2_A1;
      end
      S_R2_A1: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_src   = ACC_PROD;
        cmd.acc_shift = 2'd3;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_RXSQ_Y;
        state_d       = S_R2_A2;
      end
      S_R2_M2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RXSQ_Y;
        state_d     = S_R2_A2;
      end
      S_R2_A2: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_src   = ACC_PROD;
        cmd.acc_shift = 2'd3;
        cmd.acc_neg   = 1'b1;
        state_d       = S_R2_A3;
      end
      S_R2_A3: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_src   = ACC_RX_SQ;
        cmd.acc_shift = 2'd2;
        state_d       = S_Q0;
      end
      S_Q0: begin
        if (stat_i.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_Q0;
          state_d      = S_Q1;
        end
      end
      S_Q1: begin
        if (stat_i.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_Q1;
          state_d      = S_Q2;
        end
      end
      S_Q2: begin
        if (stat_i.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_Q2;
          state_d      = S_Q3;
        end
      end
      S_Q3: begin
        if (stat_i.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_Q3;
          state_d      = S_WAIT;
        end
      end
      S_F0: begin
        if (stat_i.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_F0;
          state_d      = S_F1;
        end
      end
      S_F1: begin
        if (stat_i.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_F1;
          state_d      = S_F2;
        end
      end
      S_F2: begin
        if (stat_i.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_F2;
          state_d      = S_WAIT;
        end
      end
      S_NULL: begin
        if (stat_i.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EMIT_NULL;
          cmd.emit_done = (phase_q == PH_DONE);
          state_d       = S_WAIT;
        end
      end
      default: state_d = S_WAIT;
    endcase
  end

  assign cmd_o = cmd;

  a_emit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> stat_i.out_free)
    else $error("result issued while output register is occupied");

  a_r2_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_R2_CHK |-> phase_q == PH_R2)
    else $error("region 2 step outside region 2");

  a_final_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_F0 |-> phase_q == PH_DONE)
    else $error("final points emitted before ellipse is done");

endmodule

`default_nettype wire

### rtl/mer_dpath.sv
// ----------------------------------------------------------------------------
// mer_dpath
// Datapath of the rasterizer: coordinate and radius registers, the shared
// multiplier, the decision accumulator and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_dpath #(
  parameter int unsigned COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire mer_pkg::dp_cmd_t             cmd_i,
  output mer_pkg::dp_stat_t                 stat_o,
  input  wire logic [COORD_BITS-1:0]        center_x_i,
  input  wire logic [COORD_BITS-1:0]        center_y_i,
  input  wire logic [COORD_BITS-1:0]        radius_x_i,
  input  wire logic [COORD_BITS-1:0]        radius_y_i,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output logic signed [COORD_BITS+1:0]      pixel_x_o,
  output logic signed [COORD_BITS+1:0]      pixel_y_o,
  output logic                              pixel_valid_o,
  output logic                              last_o,
  output logic                              done_res_o
);
  import mer_pkg::*;

  localparam int unsigned PW    = COORD_BITS + 2;      // position and pixel
  localparam int unsigned SQW   = 2 * COORD_BITS;      // squared radius
  localparam int unsigned MBW   = 2 * COORD_BITS + 3;  // multiplier b operand
  localparam int unsigned PRW   = SQW + MBW;           // product
  localparam int unsigned DEC_W = 4 * COORD_BITS + 6;  // decision, two's compl.

  logic [COORD_BITS-1:0] ctr_x_q, ctr_y_q, rad_x_q, rad_y_q;
  logic [SQW-1:0]        rx_sq_q, ry_sq_q;
  logic [PW-1:0]         pos_x_q, pos_y_q;
  logic [PRW-1:0]        prod_q, aux_q;
  logic [DEC_W-1:0]      dec_q;

  logic [PW-1:0]    tx, ty_abs;
  logic [SQW-1:0]   mul_a;
  logic [MBW-1:0]   mul_b;
  logic [PRW-1:0]   mul_p;
  logic [PRW-1:0]   acc_val;
  logic [DEC_W-1:0] acc_sh, acc_term, dec_d;

  logic          out_vld_q;
  logic [PW-1:0] out_px_q, out_py_q;
  logic          out_pv_q, out_last_q, out_done_q;
  logic [PW-1:0] px_d, py_d;
  logic          pv_d, last_d, done_d;
  logic [PW-1:0] cx, cy, ry_w;

  // tx = 2x+1, |ty| = |y-1| (y is never negative)
  assign tx     = {pos_x_q[PW-2:0], 1'b1};
  assign ty_abs = (pos_y_q == '0) ? PW'(1) : pos_y_q - PW'(1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_sel)
      MUL_RX_RX: begin
        mul_a = SQW'(rad_x_q);
        mul_b = MBW'(rad_x_q);
      end
      MUL_RY_RY: begin
        mul_a = SQW'(rad_y_q);
        mul_b = MBW'(rad_y_q);
      end
      MUL_RXSQ_RY: begin
        mul_a = rx_sq_q;
        mul_b = MBW'(rad_y_q);
      end
      MUL_RYSQ_X: begin
        mul_a = ry_sq_q;
        mul_b = MBW'(pos_x_q);
      end
      MUL_RXSQ_Y: begin
        mul_a = rx_sq_q;
        mul_b = MBW'(pos_y_q);
      end
      MUL_TX_TX: begin
        mul_a = SQW'(tx);
        mul_b = MBW'(tx);
      end
      MUL_RYSQ_P: begin
        mul_a = ry_sq_q;
        mul_b = prod_q[MBW-1:0];
      end
      MUL_TY_TY: begin
        mul_a = SQW'(ty_abs);
        mul_b = MBW'(ty_abs);
      end
      MUL_RXSQ_P: begin
        mul_a = rx_sq_q;
        mul_b = prod_q[MBW-1:0];
      end
      MUL_RXSQ_RYSQ: begin
        mul_a = rx_sq_q;
        mul_b = MBW'(ry_sq_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PRW'(mul_a) * PRW'(mul_b);

  always_comb begin
    unique case (cmd_i.acc_src)
      ACC_PROD:  acc_val = prod_q;
      ACC_AUX:   acc_val = aux_q;
      ACC_RX_SQ: acc_val = PRW'(rx_sq_q);
      ACC_RY_SQ: acc_val = PRW'(ry_sq_q);
    endcase
  end

  assign acc_sh   = DEC_W'(acc_val) << cmd_i.acc_shift;
  assign acc_term = cmd_i.acc_neg ? (~acc_sh + DEC_W'(1)) : acc_sh;
  assign dec_d    = (cmd_i.acc_clr ? '0 : dec_q) + acc_term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_x_q <= '0;
      ctr_y_q <= '0;
      rad_x_q <= '0;
      rad_y_q <= '0;
      rx_sq_q <= '0;
      ry_sq_q <= '0;
      pos_x_q <= '0;
      pos_y_q <= '0;
      prod_q  <= '0;
      aux_q   <= '0;
      dec_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        ctr_x_q <= center_x_i;
        ctr_y_q <= center_y_i;
        rad_x_q <= radius_x_i;
        rad_y_q <= radius_y_i;
        pos_x_q <= '0;
        pos_y_q <= PW'(radius_y_i);
      end else begin
        if (cmd_i.x_inc) begin
          pos_x_q <= pos_x_q + PW'(1);
        end
        if (cmd_i.y_dec) begin
          pos_y_q <= pos_y_q - PW'(1);
        end
      end
      if (cmd_i.mul_en) begin
        prod_q <= mul_p;
      end
      if (cmd_i.aux_en) begin
        aux_q <= prod_q;
      end
      if (cmd_i.rx_sq_en) begin
        rx_sq_q <= prod_q[SQW-1:0];
      end
      if (cmd_i.ry_sq_en) begin
        ry_sq_q <= prod_q[SQW-1:0];
      end
      if (cmd_i.acc_en) begin
        dec_q <= dec_d;
      end
    end
  end

  // mirrored pixel selection, wraps to PW bits
  assign cx   = PW'(ctr_x_q);
  assign cy   = PW'(ctr_y_q);
  assign ry_w = PW'(rad_y_q);

  always_comb begin
    px_d   = '0;
    py_d   = '0;
    pv_d   = 1'b1;
    last_d = 1'b0;
    done_d = 1'b0;
    unique case (cmd_i.emit_sel)
      EMIT_Q0: begin
        px_d = cx + pos_x_q;
        py_d = cy + pos_y_q;
      end
      EMIT_Q1: begin
        px_d = cx - pos_x_q;
        py_d = cy + pos_y_q;
      end
      EMIT_Q2: begin
        px_d = cx - pos_x_q;
        py_d = cy - pos_y_q;
      end
      EMIT_Q3: begin
        px_d   = cx + pos_x_q;
        py_d   = cy - pos_y_q;
        last_d = 1'b1;
      end
      EMIT_F0: begin
        px_d   = cx;
        py_d   = cy;
        done_d = 1'b1;
      end
      EMIT_F1: begin
        px_d   = cx;
        py_d   = cy + ry_w;
        done_d = 1'b1;
      end
      EMIT_F2: begin
        px_d   = cx;
        py_d   = cy - ry_w;
        last_d = 1'b1;
        done_d = 1'b1;
      end
      EMIT_NULL: begin
        pv_d   = 1'b0;
        last_d = 1'b1;
        done_d = cmd_i.emit_done;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_px_q   <= px_d;
      out_py_q   <= py_d;
      out_pv_q   <= pv_d;
      out_last_q <= last_d;
      out_done_q <= done_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign pixel_x_o     = out_px_q;
  assign pixel_y_o     = out_py_q;
  assign pixel_valid_o = out_pv_q;
  assign last_o        = out_last_q;
  assign done_res_o    = out_done_q;

  assign stat_o.out_free   = !out_vld_q || out_ready_i;
  assign stat_o.start_zero = (radius_x_i == '0) || (radius_y_i == '0);
  assign stat_o.cmp_le     = (aux_q <= prod_q);
  assign stat_o.dec_neg    = dec_q[DEC_W-1];
  assign stat_o.dec_pos    = !dec_q[DEC_W-1] && (dec_q != '0);
  assign stat_o.y_pos      = (pos_y_q != '0);

  a_y_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pos_y_q[PW-1])
    else $error("y position went negative");

  a_dec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_q[DEC_W-1] == dec_q[DEC_W-2])
    else $error("decision accumulator overflow");

endmodule

`default_nettype wire
